// ===== src/rrps_pkg.sv =====
// ----------------------------------------------------------------------------
// rrps_pkg
// Shared types, codes and sizes for the round-robin peer selector.
// ----------------------------------------------------------------------------
package rrps_pkg;

    // Table geometry
    localparam int MAX_PEERS = 32;
    localparam int PEER_W    = $clog2(MAX_PEERS);        // peer index bits
    localparam int CNT_W     = $clog2(MAX_PEERS + 1);    // peer count bits

    // Field widths
    localparam int TIME_W    = 32;
    localparam int FC_W      = 8;
    localparam int FT_W      = 16;
    localparam int PC_W      = 6;
    localparam int CFG_W     = 16;
    localparam int REG_IDX_W = 2;
    localparam int CMD_W     = 2;
    localparam int STAT_W    = 2;
    localparam int IN_DATA_W = 40;
    localparam int OUT_DATA_W = 8;

    localparam logic [FC_W-1:0] FC_MAX   = {FC_W{1'b1}};
    localparam logic [FT_W-1:0] FT_RESET = FT_W'(10);

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_MAX_FAILS    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_FAIL_TIMEOUT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_PEER_COUNT   = 2'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_SELECT  = 2'd0,
        CMD_RELEASE_OK   = 2'd1,
        CMD_RELEASE_FAIL = 2'd2,
        CMD_CLEAR   = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_EMPTY    = 2'd1,
        STAT_ALL_DOWN = 2'd2
    } status_t;

    // One table entry
    typedef struct packed {
        logic [FC_W-1:0]   fc;
        logic [TIME_W-1:0] ct;
    } entry_t;

    // Table write port
    typedef struct packed {
        logic              fc_en;
        logic              ct_en;
        logic [PEER_W-1:0] addr;
        entry_t            data;
    } tbl_wr_t;

    // Remainder unit request
    typedef struct packed {
        logic              start;
        logic [PEER_W-1:0] dividend;
        logic [CNT_W-1:0]  divisor;
    } mod_req_t;

endpackage

// ===== src/rrps_table.sv =====
// ----------------------------------------------------------------------------
// rrps_table
// Peer table: failure count and check time per peer, one write and one
// registered read per cycle. Per-field valid bits give the zero reset value.
// ----------------------------------------------------------------------------
module rrps_table (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rrps_pkg::tbl_wr_t      wr,
    input  logic [rrps_pkg::PEER_W-1:0] rd_addr,
    output rrps_pkg::entry_t       rd_data
);
    import rrps_pkg::*;

    logic [FC_W-1:0]      fc_mem [MAX_PEERS];
    logic [TIME_W-1:0]    ct_mem [MAX_PEERS];
    logic [MAX_PEERS-1:0] fc_valid_reg;
    logic [MAX_PEERS-1:0] ct_valid_reg;

    logic [FC_W-1:0]   fc_q;
    logic [TIME_W-1:0] ct_q;
    logic              fc_v_reg;
    logic              ct_v_reg;

    // Storage writes and registered read
    always_ff @(posedge clk)
    begin
        if (wr.fc_en)
        begin
            fc_mem[wr.addr] <= wr.data.fc;
        end
        if (wr.ct_en)
        begin
            ct_mem[wr.addr] <= wr.data.ct;
        end
        fc_q <= fc_mem[rd_addr];
        ct_q <= ct_mem[rd_addr];
    end

    // Valid bits: an entry never written reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fc_valid_reg <= '0;
            ct_valid_reg <= '0;
            fc_v_reg     <= 1'b0;
            ct_v_reg     <= 1'b0;
        end
        else
        begin
            if (wr.fc_en)
            begin
                fc_valid_reg[wr.addr] <= 1'b1;
            end
            if (wr.ct_en)
            begin
                ct_valid_reg[wr.addr] <= 1'b1;
            end
            fc_v_reg <= fc_valid_reg[rd_addr];
            ct_v_reg <= ct_valid_reg[rd_addr];
        end
    end

    assign rd_data.fc = fc_v_reg ? fc_q : '0;
    assign rd_data.ct = ct_v_reg ? ct_q : '0;

endmodule

// ===== src/rrps_mod_unit.sv =====
// ----------------------------------------------------------------------------
// rrps_mod_unit
// Restoring remainder unit: one dividend bit per cycle, one
// compare-and-subtract. Pulses done when the remainder is ready.
// ----------------------------------------------------------------------------
module rrps_mod_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rrps_pkg::mod_req_t          req,
    output logic                        done,
    output logic [rrps_pkg::PEER_W-1:0] remainder
);
    import rrps_pkg::*;

    localparam int STEP_W = $clog2(PEER_W);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  dvs_reg;
    logic [PEER_W-1:0] dvd_reg;

    logic [CNT_W-1:0]  trial;
    logic [CNT_W-1:0]  rem_next;

    // Shift in the next dividend bit, subtract when it fits
    always_comb
    begin
        trial    = {rem_reg[CNT_W-2:0], dvd_reg[PEER_W-1]};
        rem_next = (trial >= dvs_reg) ? (trial - dvs_reg) : trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(PEER_W - 1);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            dvd_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[PEER_W-2:0], 1'b0};
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg[PEER_W-1:0];

endmodule

// ===== src/round_robin_peer_selector.sv =====
// ----------------------------------------------------------------------------
// round_robin_peer_selector
// Load-balancer peer selector with passive health checking.
// ----------------------------------------------------------------------------
// One transaction at a time. A select on a non-empty table examines 1 to
// 32 peers: the start position is reduced modulo the peer count by a
// restoring remainder unit at one bit per cycle (5 steps), then the walk
// examines one table entry per cycle through the table's single registered
// read port. An empty table answers without the remainder unit or the
// walk. The input is not ready while a transaction is in progress; a
// finished result waits in an output register, so the next transaction can
// be accepted before it is taken. Configuration is written through
// cfg_we / cfg_index / cfg_data.
// ----------------------------------------------------------------------------
module round_robin_peer_selector (
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration
    input  logic                             cfg_we,
    input  logic [rrps_pkg::REG_IDX_W-1:0]   cfg_index,
    input  logic [rrps_pkg::CFG_W-1:0]       cfg_data,
    // Input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [rrps_pkg::IN_DATA_W-1:0]   s_tdata,  // now[31:0], first_attempt, peer_index[4:0]
    input  logic [rrps_pkg::CMD_W-1:0]       s_tuser,  // command[1:0]
    // Result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [rrps_pkg::OUT_DATA_W-1:0]  m_tdata   // status[1:0], chosen_peer[4:0], peer_disabled
);
    import rrps_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_MOD    = 5'b00010,
        S_CHECK  = 5'b00100,
        S_FAIL   = 5'b01000,
        S_RESULT = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers
    logic [FC_W-1:0] max_fails_reg;
    logic [FT_W-1:0] fail_timeout_reg;
    logic [PC_W-1:0] peer_count_reg;

    // Latched transaction
    cmd_t              cmd_in;
    logic [TIME_W-1:0] now_in;
    logic              first_in;
    logic [PEER_W-1:0] pidx_in;
    logic [TIME_W-1:0] now_reg;
    logic              first_reg;
    logic [PEER_W-1:0] pidx_reg;

    // Walk and result state
    logic [PEER_W-1:0] rr_ptr_reg, rr_ptr_next;
    logic [PEER_W-1:0] cur_reg, cur_next;
    logic [CNT_W-1:0]  step_reg, step_next;
    status_t           res_status_reg, res_status_next;
    logic [PEER_W-1:0] res_chosen_reg, res_chosen_next;
    logic              res_dis_reg, res_dis_next;
    logic              out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    // Unit connections
    tbl_wr_t           tbl_wr;
    logic [PEER_W-1:0] rd_addr;
    entry_t            rd_data;
    mod_req_t          mod_req;
    logic              mod_done;
    logic [PEER_W-1:0] mod_rem;

    // Combinational helpers
    logic              accept;
    logic [CNT_W-1:0]  n_eff;
    logic [CNT_W-1:0]  start_inc;
    logic [PEER_W-1:0] start_pos;
    logic [CNT_W-1:0]  cur_inc;
    logic [PEER_W-1:0] cur_wrap;
    logic [TIME_W-1:0] age;
    logic              stale;
    logic              blocked;
    logic [FC_W-1:0]   fc_new;

    assign cmd_in   = cmd_t'(s_tuser);
    assign now_in   = s_tdata[TIME_W-1:0];
    assign first_in = s_tdata[TIME_W];
    assign pidx_in  = s_tdata[TIME_W+PEER_W:TIME_W+1];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Peer count capped at the table size
    assign n_eff = (CNT_W'(peer_count_reg) > CNT_W'(MAX_PEERS)) ? CNT_W'(MAX_PEERS)
                                                                : CNT_W'(peer_count_reg);

    // Start position: remainder plus one, wrapped
    assign start_inc = {1'b0, mod_rem} + CNT_W'(1);
    assign start_pos = (start_inc == n_eff) ? '0 : start_inc[PEER_W-1:0];

    // Next peer of the walk
    assign cur_inc  = {1'b0, cur_reg} + CNT_W'(1);
    assign cur_wrap = (cur_inc == n_eff) ? '0 : cur_inc[PEER_W-1:0];

    // Health test of the entry just read
    assign age     = now_reg - rd_data.ct;
    assign stale   = age > TIME_W'(fail_timeout_reg);
    assign blocked = (max_fails_reg != '0) && (rd_data.fc >= max_fails_reg) && !stale;

    // Saturating failure count
    assign fc_new = (rd_data.fc == FC_MAX) ? rd_data.fc : rd_data.fc + 1'b1;

    rrps_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (tbl_wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rrps_mod_unit u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (mod_req),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        rr_ptr_next     = rr_ptr_reg;
        cur_next        = cur_reg;
        step_next       = step_reg;
        res_status_next = res_status_reg;
        res_chosen_next = res_chosen_reg;
        res_dis_next    = res_dis_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        tbl_wr          = '0;
        rd_addr         = cur_reg;
        mod_req         = '0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_status_next = STAT_OK;
                    res_chosen_next = '0;
                    res_dis_next    = 1'b0;
                    state_next      = S_RESULT;
                    unique case (cmd_in)
                        CMD_SELECT:
                        begin
                            if (n_eff == '0)
                            begin
                                res_status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                mod_req.start    = 1'b1;
                                mod_req.dividend = first_in ? rr_ptr_reg : pidx_in;
                                mod_req.divisor  = n_eff;
                                state_next       = S_MOD;
                            end
                        end
                        CMD_RELEASE_OK:
                        begin
                            tbl_wr.fc_en = 1'b1;
                            tbl_wr.addr  = pidx_in;
                        end
                        CMD_RELEASE_FAIL:
                        begin
                            if (max_fails_reg != '0)
                            begin
                                rd_addr    = pidx_in;
                                state_next = S_FAIL;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            tbl_wr.fc_en = 1'b1;
                            tbl_wr.ct_en = 1'b1;
                            tbl_wr.addr  = pidx_in;
                        end
                        default:
                        begin
                            state_next = S_RESULT;
                        end
                    endcase
                end
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    if (first_reg)
                    begin
                        rr_ptr_next = start_pos;
                    end
                    cur_next   = start_pos;
                    step_next  = '0;
                    rd_addr    = start_pos;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!blocked)
                begin
                    // Usable peer: refresh its check time once the window is over
                    tbl_wr.ct_en    = stale;
                    tbl_wr.addr     = cur_reg;
                    tbl_wr.data.ct  = now_reg;
                    res_status_next = STAT_OK;
                    res_chosen_next = cur_reg;
                    state_next      = S_RESULT;
                end
                else if ((step_reg + CNT_W'(1)) == n_eff)
                begin
                    res_status_next = STAT_ALL_DOWN;
                    res_chosen_next = '0;
                    state_next      = S_RESULT;
                end
                else
                begin
                    cur_next   = cur_wrap;
                    step_next  = step_reg + CNT_W'(1);
                    rd_addr    = cur_wrap;
                end
            end
            S_FAIL:
            begin
                tbl_wr.fc_en   = 1'b1;
                tbl_wr.ct_en   = 1'b1;
                tbl_wr.addr    = pidx_reg;
                tbl_wr.data.fc = fc_new;
                tbl_wr.data.ct = now_reg;
                res_dis_next   = (fc_new >= max_fails_reg);
                state_next     = S_RESULT;
            end
            S_RESULT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {res_dis_reg, res_chosen_reg, res_status_reg};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            rr_ptr_reg       <= '0;
            out_valid_reg    <= 1'b0;
            max_fails_reg    <= '0;
            fail_timeout_reg <= FT_RESET;
            peer_count_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rr_ptr_reg    <= rr_ptr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_MAX_FAILS:    max_fails_reg    <= cfg_data[FC_W-1:0];
                    REG_FAIL_TIMEOUT: fail_timeout_reg <= cfg_data[FT_W-1:0];
                    REG_PEER_COUNT:   peer_count_reg   <= cfg_data[PC_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            now_reg   <= now_in;
            first_reg <= first_in;
            pidx_reg  <= pidx_in;
        end
        cur_reg        <= cur_next;
        step_reg       <= step_next;
        res_status_reg <= res_status_next;
        res_chosen_reg <= res_chosen_next;
        res_dis_reg    <= res_dis_next;
        out_data_reg   <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== src/rrps_checker.sv =====
// ----------------------------------------------------------------------------
// rrps_checker
// Port-level checks for the round-robin peer selector, bound to the top.
// ----------------------------------------------------------------------------
module rrps_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [rrps_pkg::OUT_DATA_W-1:0]  m_tdata   // status[1:0], chosen_peer[4:0], peer_disabled
);
    import rrps_pkg::*;

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Only one transaction in flight: input busy after an acceptance
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready straight after acceptance");

    // Status code is always a defined one
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[1:0] == STAT_OK) || (m_tdata[1:0] == STAT_EMPTY)
                     || (m_tdata[1:0] == STAT_ALL_DOWN))
        else $error("undefined status");

    // A failing select names no peer
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1:0] != STAT_OK) |-> (m_tdata[6:2] == '0) && !m_tdata[7])
        else $error("peer or disable flag with failing status");

    // Disable flag only comes from a release, which names no peer
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[7] |-> (m_tdata[6:2] == '0))
        else $error("disable flag together with a chosen peer");

endmodule

bind round_robin_peer_selector rrps_checker u_rrps_checker (.*);
